// File: design/btc_pkg.sv
// Package for the beacon tone classifier: codes, widths and the result type.
`timescale 1ns / 1ps
package btc_pkg;

    localparam int EDGES_PER_SPAN = 20;
    localparam int EDGE_CNT_W     = $clog2(EDGES_PER_SPAN + 2);
    localparam int STAMP_W        = 32;
    localparam int CFG_IDX_W      = 8;
    localparam int S_TDATA_W      = 32;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 32;
    localparam int M_TUSER_W      = 3;

    typedef enum logic [1:0] {
        FUNC_EDGE  = 2'd0,
        FUNC_POLL  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CLS_NONE     = 2'd0,
        CLS_EXCHANGE = 2'd1,
        CLS_SERVER   = 2'd2,
        CLS_UNKNOWN  = 2'd3
    } beacon_class_t;

    localparam logic [CFG_IDX_W-1:0] REG_EXCH_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EXCH_MAX = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SERV_MIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SERV_MAX = CFG_IDX_W'(3);

    localparam logic [STAMP_W-1:0] EXCH_MIN_RST = STAMP_W'(6452);
    localparam logic [STAMP_W-1:0] EXCH_MAX_RST = STAMP_W'(6896);
    localparam logic [STAMP_W-1:0] SERV_MIN_RST = STAMP_W'(21053);
    localparam logic [STAMP_W-1:0] SERV_MAX_RST = STAMP_W'(26666);

    typedef struct packed {
        logic [STAMP_W-1:0] span_us;
        beacon_class_t      beacon_class;
        logic               detected;
    } result_t;

endpackage

// File: design/beacon_tone_classifier.sv
// Beacon tone classifier: multi-period frequency counter with span classification.
//
//   channel | direction | payload
//   s_      | in        | tdata = now_us[31:0]; tuser = func[1:0]
//   m_      | out       | tdata = span_us[31:0]; tuser = detected, beacon_class[1:0]
//   cfg_    | in        | cfg_index selects limit register, cfg_data is its value
//
// One item per cycle while s_tready is high: an edge, poll or clear updates the counter
// state at its transfer, and a poll's result lands that edge in the output register or,
// if it is held, the skid. The span is subtracted at the closing edge, so a poll costs
// only four compares. A skid entry behind the output register keeps s_tready high while
// m_tready stalls; s_tready drops only once a second poll result waits in the skid.
// aresetn is synchronous; it clears the count and restores the default limits.
`timescale 1ns / 1ps
module beacon_tone_classifier (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [btc_pkg::S_TDATA_W-1:0]    s_tdata,    // now_us[31:0]
    input  logic [btc_pkg::S_TUSER_W-1:0]    s_tuser,    // func[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [btc_pkg::M_TDATA_W-1:0]    m_tdata,    // span_us[31:0]
    output logic [btc_pkg::M_TUSER_W-1:0]    m_tuser,    // detected, beacon_class[1:0]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [btc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [btc_pkg::STAMP_W-1:0]      cfg_data
);
    import btc_pkg::*;

    localparam logic [EDGE_CNT_W-1:0] CNT_LAST = EDGE_CNT_W'(EDGES_PER_SPAN);

    logic [STAMP_W-1:0]    exch_min_reg, exch_max_reg, serv_min_reg, serv_max_reg;
    logic [EDGE_CNT_W-1:0] edge_cnt_reg;
    logic [STAMP_W-1:0]    first_stamp_reg;
    logic [STAMP_W-1:0]    cap_span_reg;
    logic                  span_ready_reg;
    logic [STAMP_W-1:0]    kept_span_reg;

    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic    s_fire;
    func_t   func;
    logic    poll_push;
    logic    in_exch, in_serv;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign func      = func_t'(s_tuser);
    assign poll_push = s_fire && (func == FUNC_POLL);

    // limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exch_min_reg <= EXCH_MIN_RST;
            exch_max_reg <= EXCH_MAX_RST;
            serv_min_reg <= SERV_MIN_RST;
            serv_max_reg <= SERV_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_EXCH_MIN) exch_min_reg <= cfg_data;
            if (cfg_index == REG_EXCH_MAX) exch_max_reg <= cfg_data;
            if (cfg_index == REG_SERV_MIN) serv_min_reg <= cfg_data;
            if (cfg_index == REG_SERV_MAX) serv_max_reg <= cfg_data;
        end
    end

    // classification of the captured span; exchange window wins on overlap
    assign in_exch = (cap_span_reg >= exch_min_reg) && (cap_span_reg <= exch_max_reg);
    assign in_serv = (cap_span_reg >= serv_min_reg) && (cap_span_reg <= serv_max_reg);

    always_comb begin
        res_next = '0;
        if (span_ready_reg) begin
            res_next.detected = 1'b1;
            res_next.span_us  = cap_span_reg;
            priority if (in_exch) res_next.beacon_class = CLS_EXCHANGE;
            else if (in_serv)     res_next.beacon_class = CLS_SERVER;
            else                  res_next.beacon_class = CLS_UNKNOWN;
        end else begin
            res_next.detected     = 1'b0;
            res_next.beacon_class = CLS_NONE;
            res_next.span_us      = kept_span_reg;
        end
    end

    // measurement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_cnt_reg    <= '0;
            first_stamp_reg <= '0;
            cap_span_reg    <= '0;
            span_ready_reg  <= 1'b0;
            kept_span_reg   <= '0;
        end else if (s_fire) begin
            unique case (func)
                FUNC_EDGE: begin
                    if (edge_cnt_reg == '0) begin
                        first_stamp_reg <= s_tdata;
                    end else if (edge_cnt_reg == CNT_LAST) begin
                        cap_span_reg   <= s_tdata - first_stamp_reg;
                        span_ready_reg <= 1'b1;
                    end
                    if (edge_cnt_reg <= CNT_LAST) begin
                        edge_cnt_reg <= edge_cnt_reg + 1'b1;
                    end
                end
                FUNC_POLL: begin
                    if (span_ready_reg) begin
                        kept_span_reg  <= cap_span_reg;
                        span_ready_reg <= 1'b0;
                        edge_cnt_reg   <= '0;
                    end
                end
                FUNC_CLEAR: begin
                    edge_cnt_reg   <= '0;
                    span_ready_reg <= 1'b0;
                    kept_span_reg  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= poll_push;
            end
        end else if (poll_push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (poll_push) begin
                out_reg <= res_next;
            end
        end else if (poll_push) begin
            skid_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.span_us;
    assign m_tuser  = {out_reg.beacon_class, out_reg.detected};

    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transfer while output register is empty");

    a_detect_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.detected == (out_reg.beacon_class != CLS_NONE)))
        else $error("detected flag and class disagree");

    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_cnt_reg <= CNT_LAST + 1'b1)
        else $error("edge count past saturation");

    a_ready_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        span_ready_reg |-> (edge_cnt_reg == CNT_LAST + 1'b1))
        else $error("span ready without a full edge count");

endmodule

// File: sim/beacon_span_checker.sv
// Scoreboard for the beacon tone classifier: predicts poll results and compares them.
`timescale 1ns / 1ps
module beacon_span_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [btc_pkg::S_TDATA_W-1:0]  s_tdata,    // now_us[31:0]
    input  logic [btc_pkg::S_TUSER_W-1:0]  s_tuser,    // func[1:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [btc_pkg::M_TDATA_W-1:0]  m_tdata,    // span_us[31:0]
    input  logic [btc_pkg::M_TUSER_W-1:0]  m_tuser,    // detected, beacon_class[1:0]
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btc_pkg::STAMP_W-1:0]    cfg_data,
    output int                             errors,
    output int                             pending
);
    import btc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // limit registers as the block should hold them
    logic [STAMP_W-1:0] exch_min, exch_max, serv_min, serv_max;

    // measurement state
    logic [EDGE_CNT_W-1:0] edge_cnt;
    logic [STAMP_W-1:0]    first_stamp, last_stamp, kept_span;
    logic                  span_ready;

    result_t span_reports_q[$];
    int      fail_cnt = 0;

    assign errors = fail_cnt;

    function automatic beacon_class_t classify_span(input logic [STAMP_W-1:0] span);
        if (span >= exch_min && span <= exch_max)
            return CLS_EXCHANGE;
        if (span >= serv_min && span <= serv_max)
            return CLS_SERVER;
        return CLS_UNKNOWN;
    endfunction

    task automatic absorb_event(input logic [1:0] func, input logic [STAMP_W-1:0] now);
        result_t rep;
        case (func)
            FUNC_EDGE: begin
                if (edge_cnt == 0)
                    first_stamp = now;
                else if (edge_cnt == EDGES_PER_SPAN) begin
                    last_stamp = now;
                    span_ready = 1'b1;
                end
                // count saturates one past the closing edge
                if (edge_cnt <= EDGES_PER_SPAN)
                    edge_cnt = edge_cnt + 1'b1;
            end
            FUNC_CLEAR: begin
                edge_cnt   = '0;
                span_ready = 1'b0;
                kept_span  = '0;
            end
            FUNC_POLL: begin
                rep.detected     = 1'b0;
                rep.beacon_class = CLS_NONE;
                if (span_ready) begin
                    kept_span        = last_stamp - first_stamp;
                    span_ready       = 1'b0;
                    edge_cnt         = '0;
                    rep.detected     = 1'b1;
                    rep.beacon_class = classify_span(kept_span);
                end
                rep.span_us = kept_span;
                span_reports_q.push_back(rep);
            end
            default: ;
        endcase
    endtask

    task automatic check_report(input logic [M_TDATA_W-1:0] data,
                                input logic [M_TUSER_W-1:0] user);
        result_t want;
        if (span_reports_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
                $display("unexpected result: det=%0b cls=%0d span=%08h",
                         user[0], user[2:1], data);
        end else begin
            want = span_reports_q.pop_front();
            if (user[0] !== want.detected || user[2:1] !== want.beacon_class ||
                data !== want.span_us) begin
                fail_cnt++;
                if (fail_cnt <= REPORT_LIMIT)
                    $display("mismatch: exp det=%0b cls=%0d span=%08h got det=%0b cls=%0d span=%08h",
                             want.detected, want.beacon_class, want.span_us,
                             user[0], user[2:1], data);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            exch_min    = EXCH_MIN_RST;
            exch_max    = EXCH_MAX_RST;
            serv_min    = SERV_MIN_RST;
            serv_max    = SERV_MAX_RST;
            edge_cnt    = '0;
            first_stamp = '0;
            last_stamp  = '0;
            kept_span   = '0;
            span_ready  = 1'b0;
            span_reports_q.delete();
            pending <= 0;
        end else begin
            // results leave before this edge's poll can add one
            if (m_tvalid && m_tready)
                check_report(m_tdata, m_tuser);
            // a poll at this edge still sees the old limits
            if (s_tvalid && s_tready)
                absorb_event(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_EXCH_MIN: exch_min = cfg_data;
                    REG_EXCH_MAX: exch_max = cfg_data;
                    REG_SERV_MIN: serv_min = cfg_data;
                    REG_SERV_MAX: serv_max = cfg_data;
                    default: ;
                endcase
            end
            pending <= span_reports_q.size();
        end
    end

endmodule

// File: sim/beacon_tone_classifier_tb.sv
// Testbench top for the beacon tone classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module beacon_tone_classifier_tb;
    import btc_pkg::*;

    localparam int         STALL_LIMIT   = 2000;
    localparam int         TARGET_ITEMS  = 1900;
    localparam int         PHASES        = 10;
    localparam int         SETTLE_CYCLES = 8;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;    // now_us[31:0]
    logic [S_TUSER_W-1:0]  s_tuser   = '0;    // func[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // span_us[31:0]
    logic [M_TUSER_W-1:0]  m_tuser;           // detected, beacon_class[1:0]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [STAMP_W-1:0]    cfg_data  = '0;

    int pending_results;
    int checker_errors;
    int max_gap     = 6;
    int sent_items  = 0;
    int idle_cycles = 0;
    int rx_hold     = 0;

    logic [STAMP_W-1:0] lim [4];  // limits as last programmed

    beacon_tone_classifier u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    beacon_span_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (checker_errors),
        .pending  (pending_results)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // result side: after each transfer, hold tready low for a drawn number of cycles
    always @(posedge aclk) begin : rx_side
        int gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                gap = $urandom_range(0, max_gap);
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= gap;
                end
            end
        end else begin
            if (rx_hold <= 1)
                m_tready <= 1'b1;
            rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // tvalid stays high across back-to-back transfers; in this task only a gap lowers it
    task automatic send_event(input logic [1:0] func, input logic [STAMP_W-1:0] now);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= now;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (func != FUNC_UNUSED)
            sent_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STAMP_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_limits(input logic [STAMP_W-1:0] e_min, input logic [STAMP_W-1:0] e_max,
                                  input logic [STAMP_W-1:0] v_min, input logic [STAMP_W-1:0] v_max);
        write_reg(REG_EXCH_MIN, e_min);
        write_reg(REG_EXCH_MAX, e_max);
        write_reg(REG_SERV_MIN, v_min);
        write_reg(REG_SERV_MAX, v_max);
        // out-of-range index must not disturb the limits
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
        cfg_valid <= 1'b0;
        lim[0] = e_min;
        lim[1] = e_max;
        lim[2] = v_min;
        lim[3] = v_max;
    endtask

    // drain all results, then give the block time to go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [STAMP_W-1:0] pick_span();
        int          k;
        logic [63:0] w_exch, w_serv;
        k      = $urandom_range(0, 3);
        w_exch = 64'(lim[1] - lim[0]) + 64'd1;
        w_serv = 64'(lim[3] - lim[2]) + 64'd1;
        case ($urandom_range(0, 9))
            0: return lim[k];
            1: return lim[k] - 32'd1;
            2: return lim[k] + 32'd1;
            3: return lim[0] + 32'(64'($urandom) % w_exch);
            4: return lim[2] + 32'(64'($urandom) % w_serv);
            5: return '0;
            6: return '1;
            default: return $urandom;
        endcase
    endfunction

    // a full run of edges whose first and last stamps give a chosen span, then polls;
    // some runs carry stray items or get cut by a clear
    task automatic run_span_sequence();
        logic [STAMP_W-1:0] t0, span;
        int                 cut_at, extra, polls;
        t0     = ($urandom_range(0, 3) == 0) ? ('1 - $urandom_range(0, 30000)) : $urandom;
        span   = pick_span();
        cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, EDGES_PER_SPAN) : -1;
        for (int i = 0; i <= EDGES_PER_SPAN; i++) begin
            if (i == cut_at)
                send_event(FUNC_CLEAR, $urandom);
            if ($urandom_range(0, 29) == 0)
                send_event(($urandom_range(0, 1) != 0) ? FUNC_POLL : FUNC_UNUSED, $urandom);
            send_event(FUNC_EDGE, (i == 0) ? t0 :
                                  (i == EDGES_PER_SPAN) ? t0 + span : $urandom);
        end
        extra = $urandom_range(0, 2);
        repeat (extra) send_event(FUNC_EDGE, $urandom);
        polls = $urandom_range(1, 2);
        repeat (polls) send_event(FUNC_POLL, $urandom);
    endtask

    task automatic run_noise_burst();
        repeat ($urandom_range(3, 8)) send_event(2'($urandom_range(0, 3)), $urandom);
    endtask

    initial begin
        int budget;
        int a, c;
        lim[0] = EXCH_MIN_RST;
        lim[1] = EXCH_MAX_RST;
        lim[2] = SERV_MIN_RST;
        lim[3] = SERV_MAX_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: poll with nothing captured, unused code, clear,
        // a span across the timestamp wrap at the exchange floor,
        // a saturating extra edge, and a repeat poll
        send_event(FUNC_POLL, '1);
        send_event(FUNC_UNUSED, '1);
        send_event(FUNC_UNUSED, '0);
        send_event(FUNC_CLEAR, '0);
        for (int i = 0; i <= EDGES_PER_SPAN; i++)
            send_event(FUNC_EDGE, (i == 0) ? 32'hFFFF_F000 :
                                  (i == EDGES_PER_SPAN) ? 32'hFFFF_F000 + EXCH_MIN_RST :
                                  32'hFFFF_F000 + 32'(i * 300));
        send_event(FUNC_EDGE, '0);
        send_event(FUNC_POLL, 32'h5555_AAAA);
        send_event(FUNC_POLL, 32'hAAAA_5555);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                case (phase)
                    1: program_limits('0, '0, '0, '0);
                    2: program_limits('1, '1, '1, '1);
                    3: program_limits('0, '1, '0, '1);
                    4: program_limits(32'd1000, 32'd30000, 32'd5000, 32'd40000);
                    5: program_limits(32'd7000, 32'd6000, 32'd30000, 32'd20000);
                    PHASES - 1: program_limits(EXCH_MIN_RST, EXCH_MAX_RST,
                                               SERV_MIN_RST, SERV_MAX_RST);
                    default: begin
                        a = $urandom;
                        c = $urandom;
                        program_limits(a, a + $urandom_range(0, 100000),
                                       c, c + $urandom_range(0, 100000));
                    end
                endcase
            end
            max_gap = (phase % 3 == 2) ? 0 : 6;
            budget  = TARGET_ITEMS * (phase + 1) / PHASES;
            while (sent_items < budget) begin
                if ($urandom_range(0, 9) == 0)
                    run_noise_burst();
                else
                    run_span_sequence();
            end
        end

        settle();
        if (checker_errors == 0 && pending_results == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
design/btc_pkg.sv
design/beacon_tone_classifier.sv
sim/beacon_span_checker.sv
sim/beacon_tone_classifier_tb.sv
